FILE: design/sstat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstat_pkg
// Types and constants shared by the sample statistics block.
// ----------------------------------------------------------------------------
package sstat_pkg;

  localparam int unsigned SAMPLE_BITS = 16;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } sample_t;

  typedef struct packed {
    logic [9:0]         min_index;
    logic [9:0]         max_index;
    logic signed [15:0] min_value;
    logic signed [15:0] max_value;
    logic signed [15:0] mean_value;
    logic [15:0]        std_deviation;
    logic [10:0]        sample_count;
    logic               too_few;
    logic               overflowed;
  } stats_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCUM,
    OP_LD_DEN,
    OP_MUL_ADD,
    OP_LD_NUM,
    OP_LD_SUB,
    OP_MUL_SUB,
    OP_LD_DIV,
    OP_DIV,
    OP_LD_SQRT,
    OP_SQRT,
    OP_LD_MEAN,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DEN,
    ST_NUM_LD,
    ST_NUM,
    ST_SUB_LD,
    ST_SUB,
    ST_DIV_LD,
    ST_DIV,
    ST_SQRT_LD,
    ST_SQRT,
    ST_MEAN,
    ST_EMIT
  } ss_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic step_zero;
    logic too_few;
  } dp_status_t;

endpackage

FILE: design/sstat_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstat_dp
// Datapath: run accumulators plus a shared serial unit for multiply,
// restoring divide and bitwise square root.
// ----------------------------------------------------------------------------
module sstat_dp import sstat_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  input  sample_t    item_i,
  output dp_status_t status_o,
  output stats_t     result_o
);

  localparam int unsigned CNT_W      = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned IDX_W      = $clog2(MAX_SAMPLES);
  localparam int unsigned SUM_W      = SAMPLE_BITS + CNT_W;
  localparam int unsigned SQ_W       = 2 * SAMPLE_BITS - 2 + CNT_W;
  localparam int unsigned NUM_W      = CNT_W + SQ_W;
  localparam int unsigned STEP_W     = $clog2(NUM_W);
  localparam int unsigned SQRT_TOP   = ((NUM_W - 1) / 2) * 2;
  localparam int unsigned SQRT_STEPS = SQRT_TOP / 2 + 1;

  // run accumulators
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SQ_W-1:0]         sq_q, sq_d;
  logic signed [15:0]      lo_val_q, lo_val_d, hi_val_q, hi_val_d;
  logic [IDX_W-1:0]        lo_idx_q, lo_idx_d, hi_idx_q, hi_idx_d;
  logic                    drop_q, drop_d;

  // serial unit
  logic [NUM_W-1:0]  mpr_q, mpr_d, mcd_q, mcd_d, acc_q, acc_d;
  logic [NUM_W-1:0]  den_q, den_d, rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [15:0]       dev_q, dev_d;

  logic signed [15:0] v;
  logic signed [31:0] v_sqr;
  logic [SUM_W-1:0]   sum_abs;
  logic [NUM_W:0]     div_r2;
  logic               div_ge;
  logic [NUM_W:0]     sqrt_t;
  logic               sqrt_ge;
  logic [NUM_W-1:0]   mul_add;
  logic [SUM_W-1:0]   quot;
  logic [SUM_W-1:0]   mean_full;

  assign v       = item_i.sample;
  assign v_sqr   = v * v;
  assign sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign div_r2  = {rem_q, mpr_q[NUM_W-1]};
  assign div_ge  = div_r2 >= {1'b0, den_q};
  assign sqrt_t  = {1'b0, mcd_q} + {1'b0, rem_q};
  assign sqrt_ge = {1'b0, acc_q} >= sqrt_t;
  assign mul_add = mpr_q[0] ? mcd_q : '0;

  always_comb begin
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    sq_d     = sq_q;
    lo_val_d = lo_val_q;
    lo_idx_d = lo_idx_q;
    hi_val_d = hi_val_q;
    hi_idx_d = hi_idx_q;
    drop_d   = drop_q;
    mpr_d    = mpr_q;
    mcd_d    = mcd_q;
    acc_d    = acc_q;
    den_d    = den_q;
    rem_d    = rem_q;
    step_d   = step_q;
    dev_d    = dev_q;
    case (cmd_i.op)
      OP_ACCUM: begin
        if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
          if (cnt_q == '0 || v <= lo_val_q) begin
            lo_val_d = v;
            lo_idx_d = cnt_q[IDX_W-1:0];
          end
          if (cnt_q == '0 || v >= hi_val_q) begin
            hi_val_d = v;
            hi_idx_d = cnt_q[IDX_W-1:0];
          end
          sum_d = sum_q + SUM_W'(v);
          sq_d  = sq_q + SQ_W'(unsigned'(v_sqr));
          cnt_d = cnt_q + 1'b1;
        end else begin
          drop_d = 1'b1;
        end
      end
      OP_LD_DEN: begin
        mpr_d  = NUM_W'(cnt_q);
        mcd_d  = NUM_W'(cnt_q - 1'b1);
        acc_d  = '0;
        step_d = STEP_W'(CNT_W - 1);
      end
      OP_MUL_ADD, OP_MUL_SUB: begin
        acc_d  = (cmd_i.op == OP_MUL_ADD) ? acc_q + mul_add : acc_q - mul_add;
        mpr_d  = mpr_q >> 1;
        mcd_d  = mcd_q << 1;
        step_d = step_q - 1'b1;
      end
      OP_LD_NUM: begin
        den_d  = acc_q;
        mpr_d  = NUM_W'(cnt_q);
        mcd_d  = NUM_W'(sq_q);
        acc_d  = '0;
        step_d = STEP_W'(CNT_W - 1);
      end
      OP_LD_SUB: begin
        mpr_d  = NUM_W'(sum_abs);
        mcd_d  = NUM_W'(sum_abs);
        step_d = STEP_W'(SUM_W - 1);
      end
      OP_LD_DIV: begin
        mpr_d  = acc_q;
        rem_d  = '0;
        step_d = STEP_W'(NUM_W - 1);
      end
      OP_DIV: begin
        rem_d  = div_ge ? NUM_W'(div_r2 - {1'b0, den_q}) : div_r2[NUM_W-1:0];
        mpr_d  = {mpr_q[NUM_W-2:0], div_ge};
        step_d = step_q - 1'b1;
      end
      OP_LD_SQRT: begin
        acc_d  = mpr_q;
        mcd_d  = '0;
        rem_d  = NUM_W'(1) << SQRT_TOP;
        step_d = STEP_W'(SQRT_STEPS);
      end
      OP_SQRT: begin
        if (sqrt_ge) begin
          acc_d = acc_q - sqrt_t[NUM_W-1:0];
          mcd_d = (mcd_q >> 1) + rem_q;
        end else begin
          mcd_d = mcd_q >> 1;
        end
        rem_d  = rem_q >> 2;
        step_d = step_q - 1'b1;
      end
      OP_LD_MEAN: begin
        if (cnt_q < CNT_W'(2)) begin
          dev_d = '0;
        end else if (|mcd_q[NUM_W-1:16]) begin
          dev_d = 16'hFFFF;
        end else begin
          dev_d = mcd_q[15:0];
        end
        mpr_d  = NUM_W'(sum_abs);
        den_d  = NUM_W'(cnt_q);
        rem_d  = '0;
        step_d = STEP_W'(NUM_W - 1);
      end
      OP_EMIT: begin
        cnt_d    = '0;
        sum_d    = '0;
        sq_d     = '0;
        lo_val_d = '0;
        lo_idx_d = '0;
        hi_val_d = '0;
        hi_idx_d = '0;
        drop_d   = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_q    <= '0;
      sq_q     <= '0;
      lo_val_q <= '0;
      lo_idx_q <= '0;
      hi_val_q <= '0;
      hi_idx_q <= '0;
      drop_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      sq_q     <= sq_d;
      lo_val_q <= lo_val_d;
      lo_idx_q <= lo_idx_d;
      hi_val_q <= hi_val_d;
      hi_idx_q <= hi_idx_d;
      drop_q   <= drop_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mpr_q <= mpr_d;
    mcd_q <= mcd_d;
    acc_q <= acc_d;
    den_q <= den_d;
    rem_q <= rem_d;
    dev_q <= dev_d;
  end

  assign quot      = mpr_q[SUM_W-1:0];
  assign mean_full = sum_q[SUM_W-1] ? SUM_W'(-quot) : quot;

  assign status_o.step_zero = (step_q == '0);
  assign status_o.too_few   = (cnt_q < CNT_W'(2));

  assign result_o.min_index     = 10'(lo_idx_q);
  assign result_o.max_index     = 10'(hi_idx_q);
  assign result_o.min_value     = lo_val_q;
  assign result_o.max_value     = hi_val_q;
  assign result_o.mean_value    = mean_full[15:0];
  assign result_o.std_deviation = dev_q;
  assign result_o.sample_count  = 11'(cnt_q);
  assign result_o.too_few       = (cnt_q < CNT_W'(2));
  assign result_o.overflowed    = drop_q;

endmodule

FILE: design/sstat_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstat_ctrl
// Controller: takes items while idle, then sequences the serial unit
// through denominator, numerator, divide, square root and mean, or mean alone for under two samples.
// ----------------------------------------------------------------------------
module sstat_ctrl import sstat_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       last_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  ss_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    busy_o    = 1'b1;
    done_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.op = OP_ACCUM;
          if (last_i) begin
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        if (status_i.too_few) begin
          cmd_o.op = OP_LD_MEAN;
          state_d  = ST_MEAN;
        end else begin
          cmd_o.op = OP_LD_DEN;
          state_d  = ST_DEN;
        end
      end
      ST_DEN: begin
        cmd_o.op = OP_MUL_ADD;
        if (status_i.step_zero) state_d = ST_NUM_LD;
      end
      ST_NUM_LD: begin
        cmd_o.op = OP_LD_NUM;
        state_d  = ST_NUM;
      end
      ST_NUM: begin
        cmd_o.op = OP_MUL_ADD;
        if (status_i.step_zero) state_d = ST_SUB_LD;
      end
      ST_SUB_LD: begin
        cmd_o.op = OP_LD_SUB;
        state_d  = ST_SUB;
      end
      ST_SUB: begin
        cmd_o.op = OP_MUL_SUB;
        if (status_i.step_zero) state_d = ST_DIV_LD;
      end
      ST_DIV_LD: begin
        cmd_o.op = OP_LD_DIV;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        if (status_i.step_zero) state_d = ST_SQRT_LD;
      end
      ST_SQRT_LD: begin
        cmd_o.op = OP_LD_SQRT;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQRT;
        if (status_i.step_zero) begin
          state_d = ST_MEAN;
        end
      end
      ST_MEAN: begin
        // the mean divide runs here; its operands were loaded on entry
        cmd_o.op = OP_DIV;
        if (status_i.step_zero) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.op = OP_EMIT;
        done_o   = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (state_q == ST_SQRT && status_i.step_zero) begin
      // root done: load mean operands on the way out
      cmd_o.op = OP_LD_MEAN;
    end
  end

endmodule

FILE: design/sample_statistics_min_max_mean_stddev.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_statistics_min_max_mean_stddev
// Min, max with indices, mean and sample standard deviation over a run
// of signed Q8.8 samples.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  input     start & !busy         item_i   (sample_t)
//  output    done_o, one cycle     result_o (stats_t)
//
//  Non-final items are taken one per cycle while busy is low.
//  A final item raises busy while the shared serial multiply / divide / root
//  unit runs (only the mean divide with fewer than two samples);
//  done_o pulses in the last busy cycle.
//  The receiver cannot stall; reset clears all run state.
// ----------------------------------------------------------------------------
module sample_statistics_min_max_mean_stddev import sstat_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  sample_t item_i,
  output logic    done_o,
  output stats_t  result_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sstat_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .last_i   (item_i.last),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  sstat_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .status_o (status),
    .result_o (result_o)
  );

endmodule

FILE: design/sstat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstat_checker
// Port-level checks on the sample statistics block.
// ----------------------------------------------------------------------------
module sstat_checker import sstat_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input sample_t item_i,
  input logic    done_o,
  input stats_t  result_o
);

  ap_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result outside a busy window");

  ap_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.last) |=> (busy && !done_o))
    else $error("final item did not start the computation");

  ap_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy && !done_o))
    else $error("block not idle after result");

  ap_few_dev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.too_few) |-> (result_o.std_deviation == 16'd0))
    else $error("deviation nonzero with too few samples");

  ap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.sample_count != 11'd0))
    else $error("result with empty run");

endmodule

bind sample_statistics_min_max_mean_stddev sstat_checker u_sstat_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);

FILE: tb/sv/sample_statistics_min_max_mean_stddev_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_statistics_min_max_mean_stddev_tb
// Self-checking bench for the run statistics block. A queue of sample items
// feeds a clocked driver. A monitor folds every accepted item into a local
// model of the running min/max/sum/sum-of-squares state and predicts the
// statistics at the end of each run. Each done_o result is compared field by
// field against the oldest prediction. Directed runs come first, then random
// runs of mixed length and value spread, including one that overruns
// capacity.
// ----------------------------------------------------------------------------
module sample_statistics_min_max_mean_stddev_tb import sstat_pkg::*;;

  localparam int unsigned MAX_SAMPLES = 1024;

  typedef enum {VS_FULL, VS_EDGE, VS_SMALL, VS_NEAR} value_style_e;

  typedef struct {
    sample_t     item;
    int unsigned gap;
    bit          drain;
  } feed_item_t;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start;
  logic    busy;
  sample_t item_i;
  logic    done_o;
  stats_t  result_o;

  feed_item_t  sample_feed[$];
  stats_t      expected_stats[$];
  int unsigned items_total;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_count = 0;
  bit          item_taken = 1'b0;

  // running state of the run in progress
  int unsigned     run_count = 0;
  longint          run_sum = 0;
  longint unsigned run_sq = 0;
  longint          low_value = 0;
  longint          high_value = 0;
  int unsigned     low_index = 0;
  int unsigned     high_index = 0;
  bit              dropped = 1'b0;

  sample_statistics_min_max_mean_stddev #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned probe;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      probe = root | (64'd1 << b);
      if (probe * probe <= x) root = probe;
    end
    return root;
  endfunction

  task automatic fold_sample(input sample_t s, output bit emits, output stats_t r);
    longint          v;
    longint unsigned num;
    longint unsigned den;
    longint unsigned dev;
    v = $signed(s.sample);
    emits = s.last;
    r = '0;
    if (run_count < MAX_SAMPLES) begin
      if (run_count == 0 || v <= low_value) begin
        low_value = v;
        low_index = run_count;
      end
      if (run_count == 0 || v >= high_value) begin
        high_value = v;
        high_index = run_count;
      end
      run_sum += v;
      run_sq += longint'(v * v);
      run_count++;
    end else begin
      dropped = 1'b1;
    end
    if (!s.last) return;

    dev = 0;
    if (run_count >= 2) begin
      num = longint'(run_count) * run_sq - longint'(run_sum * run_sum);
      den = longint'(run_count) * longint'(run_count - 1);
      dev = int_sqrt(num / den);
      if (dev > 64'hFFFF) dev = 64'hFFFF;
    end
    r.min_index     = 10'(low_index);
    r.max_index     = 10'(high_index);
    r.min_value     = 16'(low_value);
    r.max_value     = 16'(high_value);
    r.mean_value    = (run_count != 0) ? 16'(run_sum / longint'(run_count)) : '0;
    r.std_deviation = 16'(dev);
    r.sample_count  = 11'(run_count);
    r.too_few       = (run_count < 2);
    r.overflowed    = dropped;

    run_count  = 0;
    run_sum    = 0;
    run_sq     = 0;
    low_value  = 0;
    high_value = 0;
    low_index  = 0;
    high_index = 0;
    dropped    = 1'b0;
  endtask

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                results_seen, name, got, want));
    end
  endtask

  task automatic compare_stats(stats_t got, stats_t want);
    check_field("min_index", got.min_index, want.min_index);
    check_field("max_index", got.max_index, want.max_index);
    check_field("min_value", got.min_value, want.min_value);
    check_field("max_value", got.max_value, want.max_value);
    check_field("mean_value", got.mean_value, want.mean_value);
    check_field("std_deviation", got.std_deviation, want.std_deviation);
    check_field("sample_count", got.sample_count, want.sample_count);
    check_field("too_few", got.too_few, want.too_few);
    check_field("overflowed", got.overflowed, want.overflowed);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic int unsigned pick_run_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return 1;
    if (r < 70) return $urandom_range(8, 2);
    if (r < 95) return $urandom_range(32, 9);
    return $urandom_range(100, 33);
  endfunction

  function automatic logic signed [15:0] pick_value(value_style_e style,
                                                    logic signed [15:0] base);
    int s;
    case (style)
      VS_EDGE: begin
        case ($urandom_range(6))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          3: return -16'sd1;
          4: return 16'sh5555;
          5: return 16'shAAAA;
          default: return 16'sh0001;
        endcase
      end
      VS_SMALL: begin
        s = int'($urandom_range(1024)) - 512;
        return 16'(s);
      end
      VS_NEAR: begin
        s = int'(base) + int'($urandom_range(4)) - 2;
        return 16'(s);
      end
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_sample(logic signed [15:0] value, bit last, int unsigned gap,
                             bit drain);
    feed_item_t p;
    p.item.sample = value;
    p.item.last   = last;
    p.gap         = gap;
    p.drain       = drain;
    sample_feed.push_back(p);
  endtask

  task automatic queue_run(int unsigned len, value_style_e style, bit drain);
    bit                 burst;
    logic signed [15:0] base;
    burst = ($urandom_range(9) < 3);
    base  = 16'($urandom);
    for (int unsigned k = 0; k < len; k++) begin
      push_sample(pick_value(style, base), k == len - 1, burst ? 0 : pick_gap(),
                  drain && k == 0);
    end
  endtask

  // driver: present the next item once the current one is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (sample_feed.size() == 0) begin
        start <= 1'b0;
      end else if (idle_count < sample_feed[0].gap) begin
        start      <= 1'b0;
        idle_count <= idle_count + 1;
      end else if (sample_feed[0].drain && expected_stats.size() != 0) begin
        start <= 1'b0;
      end else begin
        item_i     <= sample_feed[0].item;
        start      <= 1'b1;
        idle_count <= 0;
        void'(sample_feed.pop_front());
      end
    end
  end

  // monitor: predict on accepted items, check on done_o
  always @(posedge clk_i) begin
    stats_t want;
    bit     emits;
    item_taken = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        item_taken = 1'b1;
        items_taken++;
        fold_sample(item_i, emits, want);
        if (emits) expected_stats.push_back(want);
      end
      if (done_o) begin
        results_seen++;
        if (expected_stats.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", results_seen));
        end else begin
          want = expected_stats.pop_front();
          compare_stats(result_o, want);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;

    // single samples at both extremes; first one waits for an empty pipe
    push_sample(16'sh7FFF, 1'b1, pick_gap(), 1'b1);
    push_sample(16'sh8000, 1'b1, pick_gap(), 1'b0);
    // widest spread
    push_sample(16'sh8000, 1'b0, pick_gap(), 1'b0);
    push_sample(16'sh7FFF, 1'b1, pick_gap(), 1'b0);
    // all equal: latest index wins for both
    for (int k = 0; k < 4; k++) push_sample(16'sh0100, k == 3, pick_gap(), 1'b0);
    // negative mean truncates toward zero
    push_sample(-16'sd3, 1'b0, pick_gap(), 1'b0);
    push_sample(-16'sd2, 1'b1, pick_gap(), 1'b0);
    push_sample(16'sh5555, 1'b0, pick_gap(), 1'b0);
    push_sample(16'shAAAA, 1'b0, pick_gap(), 1'b0);
    push_sample(16'sh0000, 1'b0, pick_gap(), 1'b0);
    push_sample(-16'sd1, 1'b0, pick_gap(), 1'b0);
    push_sample(16'sh0001, 1'b1, pick_gap(), 1'b0);
    // repeated min and max at several positions
    push_sample(16'sd7, 1'b0, pick_gap(), 1'b1);
    push_sample(-16'sd7, 1'b0, pick_gap(), 1'b0);
    push_sample(16'sd7, 1'b0, pick_gap(), 1'b0);
    push_sample(-16'sd7, 1'b0, pick_gap(), 1'b0);
    push_sample(16'sd0, 1'b1, pick_gap(), 1'b0);

    while (sample_feed.size() < 330) begin
      queue_run(pick_run_len(), value_style_e'($urandom_range(3)), $urandom_range(9) == 0);
    end
    // overruns capacity; the final item itself is dropped
    queue_run(MAX_SAMPLES + $urandom_range(6, 1), value_style_e'($urandom_range(3)), 1'b0);
    while (sample_feed.size() < 1700) begin
      queue_run(pick_run_len(), value_style_e'($urandom_range(3)), $urandom_range(9) == 0);
    end
    items_total = sample_feed.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (items_taken != items_total) @(posedge clk_i);
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
